// ----- rtl/bttb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bttb_pkg: shared types and constants of the bitmap text blitter
// Holds the store layout, operation and register codes, the queue entry
// and the character to glyph slot mapping.
// ----------------------------------------------------------------------------
package bttb_pkg;

   // glyph store layout: eight rows per slot, 64 slots
   localparam int SLOT_W      = 6;
   localparam int ROW_W       = 3;
   localparam int STORE_AW    = SLOT_W + ROW_W;
   localparam int STORE_DEPTH = 1 << STORE_AW;
   localparam int PATTERN_W   = 8;
   localparam int CURSOR_W    = 16;

   // operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DRAW = 1'b1;

   // register indexes
   localparam logic [2:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_START_COLUMN = 3'd2;
   localparam logic [2:0] CSR_START_ROW    = 3'd3;
   localparam logic [2:0] CSR_INK_COLOR    = 3'd4;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

   typedef struct packed {
      logic [12:0] frame_width;
      logic [12:0] frame_height;
      logic [11:0] start_column;
      logic [11:0] start_row;
      logic [23:0] ink_color;
   } cfg_type;

   // one classified item between front and back
   typedef struct packed {
      logic                 op;
      logic                 load_ok;
      logic [SLOT_W-1:0]    slot;
      logic [ROW_W-1:0]     row;
      logic [PATTERN_W-1:0] pattern;
      logic [CURSOR_W-1:0]  cursor;
   } entry_type;

   typedef enum logic {
      BK_IDLE,
      BK_DRAW
   } bk_state_type;

   // map a character code onto its glyph slot
   function automatic logic [SLOT_W-1:0] slot_of(input logic [7:0] code);
      logic [SLOT_W-1:0] slot;
      slot = {1'b0, code[4:0]};
      if (code == 8'h20) begin
         slot = 6'd0;
      end else if (code >= 8'h30 && code <= 8'h39) begin
         slot = 6'(code - 8'h30) + 6'd27;
      end else begin
         case (code)
            8'h2e:   slot = 6'd37;
            8'h2d:   slot = 6'd38;
            8'h2f:   slot = 6'd39;
            8'h7c:   slot = 6'd40;
            8'h3c:   slot = 6'd41;
            8'h3e:   slot = 6'd42;
            default: slot = {1'b0, code[4:0]};
         endcase
      end
      return slot;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/bttb_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bttb_req_if: request channel of the text blitter
// Carries glyph row loads and character draws with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bttb_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] char_code;
   logic       first_char;
   logic [5:0] glyph_slot;
   logic [2:0] glyph_row;
   logic [7:0] row_pattern;

   modport source (
      output valid, op, char_code, first_char, glyph_slot, glyph_row, row_pattern,
      input  ready
   );
   modport sink (
      input  valid, op, char_code, first_char, glyph_slot, glyph_row, row_pattern,
      output ready
   );
endinterface
`default_nettype wire

// ----- rtl/bttb_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bttb_rsp_if: response channel of the text blitter
// Carries one framebuffer row write per glyph row of a draw with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bttb_rsp_if;
   logic        valid;
   logic        ready;
   logic [24:0] row_address;
   logic [7:0]  write_mask;
   logic [31:0] pixel_value;
   logic        last_row;

   modport source (
      output valid, row_address, write_mask, pixel_value, last_row,
      input  ready
   );
   modport sink (
      input  valid, row_address, write_mask, pixel_value, last_row,
      output ready
   );
endinterface
`default_nettype wire

// ----- rtl/bitmap_text_blitter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// The first row write of a character passes the queue, the draw latch, the glyph store read
// and stage one, then the output register. A draw issues one glyph store read per row, and
// the back end takes no new item until its last row is issued; a row load is written on dequeue.
// Reset clears handshake state, the queue and the cursor and restores register defaults;
// the glyph store is not cleared and holds nothing defined until loaded.
// ----------------------------------------------------------------------------
// bitmap_text_blitter: character generator for a 32-bit framebuffer
// Loads glyph rows into a store and turns each drawn character into
// clipped framebuffer row writes.
// ----------------------------------------------------------------------------
module bitmap_text_blitter
   import bttb_pkg::*;
#(
   parameter int GLYPH_WIDTH  = 8,
   parameter int GLYPH_HEIGHT = 8,
   parameter int GLYPH_GAP    = 1,
   parameter int GLYPH_COUNT  = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   bttb_req_if.sink         req_ch,
   bttb_rsp_if.source       rsp_ch,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_wdata
);

   cfg_type   cfg_ff;
   logic      push_valid;
   logic      push_ready;
   entry_type push_data;
   logic      pop_valid;
   logic      pop_ready;
   entry_type pop_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= 13'd320;
         cfg_ff.frame_height <= 13'd240;
         cfg_ff.start_column <= 12'd0;
         cfg_ff.start_row    <= 12'd0;
         cfg_ff.ink_color    <= 24'hffffff;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  cfg_ff.frame_width  <= csr_wdata[12:0];
            CSR_FRAME_HEIGHT: cfg_ff.frame_height <= csr_wdata[12:0];
            CSR_START_COLUMN: cfg_ff.start_column <= csr_wdata[11:0];
            CSR_START_ROW:    cfg_ff.start_row    <= csr_wdata[11:0];
            CSR_INK_COLOR:    cfg_ff.ink_color    <= csr_wdata;
            default:          cfg_ff <= cfg_ff;
         endcase
      end
   end

   bttb_front #(
      .GLYPH_WIDTH  (GLYPH_WIDTH),
      .GLYPH_HEIGHT (GLYPH_HEIGHT),
      .GLYPH_GAP    (GLYPH_GAP),
      .GLYPH_COUNT  (GLYPH_COUNT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .start_column (cfg_ff.start_column),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_data    (push_data)
   );

   bttb_queue #(
      .DEPTH (2)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   bttb_back #(
      .GLYPH_WIDTH  (GLYPH_WIDTH),
      .GLYPH_HEIGHT (GLYPH_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_ch    (rsp_ch)
   );

endmodule
`default_nettype wire

// ----- rtl/bttb_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bttb_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bttb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- rtl/bttb_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bttb_front: request classification
// Maps characters to glyph slots, checks loads and tracks the cursor so
// that each queued draw carries its resolved column.
// ----------------------------------------------------------------------------
module bttb_front
   import bttb_pkg::*;
#(
   parameter int GLYPH_WIDTH  = 8,
   parameter int GLYPH_HEIGHT = 8,
   parameter int GLYPH_GAP    = 1,
   parameter int GLYPH_COUNT  = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   bttb_req_if.sink        req_ch,
   input  wire logic [11:0] start_column,
   output      logic       push_valid,
   input  wire logic       push_ready,
   output      entry_type  push_data
);

   localparam logic [CURSOR_W:0] ADVANCE = (CURSOR_W+1)'(GLYPH_WIDTH + GLYPH_GAP);

   logic [CURSOR_W-1:0] cursor_ff;
   logic [CURSOR_W-1:0] cursor_in;
   logic [CURSOR_W-1:0] cursor_now;
   logic [CURSOR_W:0]   cursor_sum;
   logic                accept;

   assign push_valid   = req_ch.valid;
   assign req_ch.ready = push_ready;
   assign accept       = req_ch.valid && push_ready;

   // resolve the cursor for this draw and its saturated successor
   always_comb begin
      cursor_now = req_ch.first_char ? CURSOR_W'(start_column) : cursor_ff;
      cursor_sum = {1'b0, cursor_now} + ADVANCE;
      cursor_in  = cursor_sum[CURSOR_W] ? {CURSOR_W{1'b1}} : cursor_sum[CURSOR_W-1:0];
   end

   // classify the item
   always_comb begin
      push_data.op      = req_ch.op;
      push_data.load_ok = ({1'b0, req_ch.glyph_slot} < (SLOT_W+1)'(GLYPH_COUNT)) &&
                          ({1'b0, req_ch.glyph_row} < (ROW_W+1)'(GLYPH_HEIGHT));
      push_data.slot    = (req_ch.op == OP_DRAW) ? slot_of(req_ch.char_code)
                                                 : req_ch.glyph_slot;
      push_data.row     = req_ch.glyph_row;
      push_data.pattern = req_ch.row_pattern;
      push_data.cursor  = cursor_now;
   end

   // advance the cursor on each accepted draw
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
      end else if (accept && req_ch.op == OP_DRAW) begin
         cursor_ff <= cursor_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/bttb_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bttb_queue: short queue between front and back
// Register based FIFO of classified items.
// ----------------------------------------------------------------------------
module bttb_queue
   import bttb_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_valid,
   output      logic      push_ready,
   input  wire entry_type push_data,
   output      logic      pop_valid,
   input  wire logic      pop_ready,
   output      entry_type pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // store the item
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   // advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

// ----- rtl/bttb_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bttb_back: glyph store and row writer
// Writes glyph rows into the store and, per draw, reads one glyph row a
// cycle while not stalled, clips it, emits one framebuffer row write.
// ----------------------------------------------------------------------------
module bttb_back
   import bttb_pkg::*;
#(
   parameter int GLYPH_WIDTH  = 8,
   parameter int GLYPH_HEIGHT = 8
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire logic      pop_valid,
   output      logic      pop_ready,
   input  wire entry_type pop_data,
   bttb_rsp_if.source     rsp_ch
);

   bk_state_type         state_ff;
   bk_state_type         state_in;
   logic [ROW_W-1:0]     row_ff;
   logic [SLOT_W-1:0]    draw_slot_ff;
   logic [CURSOR_W-1:0]  draw_cursor_ff;
   logic                 row_last;
   logic                 advance;
   logic                 issue;
   logic                 start_draw;
   logic                 ram_we;
   logic [PATTERN_W-1:0] ram_rd_data;

   // stage one: read issued, row product ready
   logic                 s1_valid_ff;
   logic                 s1_in_frame_ff;
   logic [25:0]          s1_prod_ff;
   logic [CURSOR_W-1:0]  s1_cursor_ff;
   logic                 s1_last_ff;
   logic [12:0]          py;
   logic [25:0]          prod;

   // stage two: clipped row write
   logic [7:0]           mask;
   logic [26:0]          addr_sum;
   logic [24:0]          addr;
   logic [CURSOR_W:0]    col_x;

   // output register
   logic                 out_valid_ff;
   logic [24:0]          out_addr_ff;
   logic [7:0]           out_mask_ff;
   logic                 out_last_ff;

   assign advance  = !out_valid_ff || rsp_ch.ready;
   assign row_last = row_ff == ROW_W'(GLYPH_HEIGHT - 1);

   bttb_ram #(
      .WIDTH (PATTERN_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr ({pop_data.slot, pop_data.row}),
      .wr_data (pop_data.pattern),
      .rd_en   (issue),
      .rd_addr ({draw_slot_ff, row_ff}),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (pop_valid && pop_data.op == OP_DRAW) begin
               state_in = BK_DRAW;
            end
         end
         BK_DRAW: begin
            if (issue && row_last) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      pop_ready  = 1'b0;
      issue      = 1'b0;
      ram_we     = 1'b0;
      start_draw = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            pop_ready  = 1'b1;
            ram_we     = pop_valid && pop_data.op == OP_LOAD && pop_data.load_ok;
            start_draw = pop_valid && pop_data.op == OP_DRAW;
         end
         BK_DRAW: begin
            issue = advance;
         end
         default: begin
            pop_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // latch the draw and step through its rows
   always_ff @(posedge clock) begin
      if (start_draw) begin
         draw_slot_ff   <= pop_data.slot;
         draw_cursor_ff <= pop_data.cursor;
         row_ff         <= '0;
      end else if (issue) begin
         row_ff <= row_ff + 1'b1;
      end
   end

   // row product for stage one
   always_comb begin
      py   = 13'(cfg.start_row) + 13'(row_ff);
      prod = py * cfg.frame_width;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_in_frame_ff <= py < cfg.frame_height;
         s1_prod_ff     <= prod;
         s1_cursor_ff   <= draw_cursor_ff;
         s1_last_ff     <= row_last;
      end
   end

   // clip the glyph row against the frame
   always_comb begin
      mask  = '0;
      col_x = '0;
      for (int col = 0; col < GLYPH_WIDTH; col++) begin
         col_x = {1'b0, s1_cursor_ff} + (CURSOR_W+1)'(col);
         if (s1_in_frame_ff && ram_rd_data[GLYPH_WIDTH-1-col] &&
             col_x < (CURSOR_W+1)'(cfg.frame_width)) begin
            mask[GLYPH_WIDTH-1-col] = 1'b1;
         end
      end
      addr_sum = 27'(s1_prod_ff) + 27'(s1_cursor_ff);
      addr     = (mask != '0) ? addr_sum[24:0] : '0;
   end

   // hold the row write until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         out_addr_ff <= addr;
         out_mask_ff <= mask;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.row_address = out_addr_ff;
   assign rsp_ch.write_mask  = out_mask_ff;
   assign rsp_ch.pixel_value = {ALPHA_OPAQUE, cfg.ink_color};
   assign rsp_ch.last_row    = out_last_ff;

endmodule
`default_nettype wire
